@@ rtl/bitplane_popcount_dot_product_macros.svh @@
// assertion macros used by the checker of the bit-plane dot product block
`ifndef BITPLANE_POPCOUNT_DOT_PRODUCT_MACROS_SVH
`define BITPLANE_POPCOUNT_DOT_PRODUCT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define BPDP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bpdp: same-cycle check failed");

// consequent checked in the cycle after the antecedent
`define BPDP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bpdp: next-cycle check failed");

`endif

@@ rtl/bpdp_pkg.sv @@
// constants, types and popcount helper for the bit-plane dot product block
package bpdp_pkg;

    localparam int DOC_W        = 64;
    localparam int PLANE_COUNT  = 4;
    localparam int PLANE_INPUTS = 4;
    localparam int PLANES_USED  = (PLANE_COUNT < PLANE_INPUTS) ? PLANE_COUNT : PLANE_INPUTS;
    localparam int NBYTES_W     = 4;
    localparam int BYTES        = DOC_W / 8;
    localparam int POP_W        = 7;
    localparam int WEIGHT_W     = POP_W + 1;
    localparam int SUM_W        = POP_W + PLANES_USED;
    localparam int ACC_W        = 32;
    localparam int FIELDS_W     = DOC_W * (1 + PLANE_INPUTS) + NBYTES_W;
    localparam int S_TDATA_W    = ((FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W    = ACC_W;
    localparam int APB_DATA_W   = 32;
    localparam int APB_ADDR_W   = 2;

    localparam logic [DOC_W-1:0] EVEN_BITS = 64'h5555_5555_5555_5555;

    // register indexes
    localparam logic [0:0] REG_TWO_BIT_CODES = 1'b0;

    typedef logic [PLANE_INPUTS-1:0][DOC_W-1:0] t_plane_words;

    typedef struct packed {
        logic             valid;
        logic             last;
        logic [SUM_W-1:0] sum;
    } t_sum_beat;

    // parallel bit count, six folding steps
    function automatic logic [POP_W-1:0] pop64(input logic [DOC_W-1:0] v);
        logic [DOC_W-1:0] x;
        x = v - ((v >> 1) & 64'h5555_5555_5555_5555);
        x = (x & 64'h3333_3333_3333_3333) + ((x >> 2) & 64'h3333_3333_3333_3333);
        x = (x + (x >> 4)) & 64'h0f0f_0f0f_0f0f_0f0f;
        x = x + (x >> 8);
        x = x + (x >> 16);
        x = x + (x >> 32);
        return x[POP_W-1:0];
    endfunction

endpackage

@@ rtl/bpdp_popcount.sv @@
// masks the document word and forms the weighted plane popcount sum
module bpdp_popcount (
    input  logic [bpdp_pkg::DOC_W-1:0]    i_doc_word,
    input  bpdp_pkg::t_plane_words        i_planes,
    input  logic [bpdp_pkg::NBYTES_W-1:0] i_valid_bytes,
    input  logic                          i_two_bit,
    output logic [bpdp_pkg::SUM_W-1:0]    o_sum
);
    import bpdp_pkg::*;

    logic [DOC_W-1:0]    word;
    logic [DOC_W-1:0]    lo;
    logic [DOC_W-1:0]    hi;
    logic [WEIGHT_W-1:0] weight [PLANES_USED];

    // bytes at or above the count are zeroed; counts above eight keep all
    always_comb begin
        for (int b = 0; b < BYTES; b++) begin
            word[b*8 +: 8] = (NBYTES_W'(b) < i_valid_bytes) ? i_doc_word[b*8 +: 8] : 8'h00;
        end
    end

    assign lo = i_two_bit ? (word & EVEN_BITS) : word;
    assign hi = i_two_bit ? ((word >> 1) & EVEN_BITS) : '0;

    always_comb begin
        for (int p = 0; p < PLANES_USED; p++) begin
            weight[p] = WEIGHT_W'(pop64(lo & i_planes[p]))
                      + {pop64(hi & i_planes[p]), 1'b0};
        end
    end

    always_comb begin
        o_sum = '0;
        for (int p = 0; p < PLANES_USED; p++) begin
            o_sum = o_sum + (SUM_W'(weight[p]) << p);
        end
    end

endmodule

@@ rtl/bpdp_accum.sv @@
// running total and result register with handshake to the output side
module bpdp_accum (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  bpdp_pkg::t_sum_beat            i_beat,
    output logic                           o_take,
    input  logic                           i_m_tready,
    output logic                           o_m_tvalid,
    output logic [bpdp_pkg::M_TDATA_W-1:0] o_m_tdata
);
    import bpdp_pkg::*;

    logic [ACC_W-1:0] r_total;
    logic [ACC_W-1:0] n_total;
    logic             r_out_valid;
    logic             n_out_valid;
    logic [ACC_W-1:0] r_out_data;

    // a beat without last only folds into the total and never waits
    assign o_take  = i_beat.valid && (!i_beat.last || !r_out_valid || i_m_tready);
    assign n_total = r_total + ACC_W'(i_beat.sum);

    // a new result replaces one that leaves in the same cycle
    assign n_out_valid = (o_take && i_beat.last) || (r_out_valid && !i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (o_take) begin
                if (i_beat.last) begin
                    r_total <= '0;
                end else begin
                    r_total <= n_total;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_beat.last) begin
            r_out_data <= n_total;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

@@ rtl/bitplane_popcount_dot_product.sv @@
// top level of the bit-plane popcount dot product block
//
// input beats arrive on the s_axis channel: one document word, the matching
// word of each query plane and a valid byte count per beat, tlast on the
// final word of a document vector. each beat adds its weighted popcount sum
// to a 32-bit running total that wraps; a beat with tlast sends the total,
// itself included, on m_axis and clears it. other beats give no output.
// two_bit_codes (apb address 0) picks one-bit or two-bit document codes and
// should only be written while no vector is in flight.
// one beat is taken every cycle unless m_axis holds up a tlast beat; the
// figure is set by the single pass from input register through popcount and
// plane sum register to the accumulator; its result register drives m_axis.
// when m_axis stalls with a result pending, beats without tlast keep flowing;
// the next tlast beat waits in the sum register and s_axis_tready drops once
// the input register behind it is also full.
// synchronous reset clears the pipeline valids, the running total and the
// mode register; pready is always high.
module bitplane_popcount_dot_product (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // apb configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [bpdp_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [bpdp_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [bpdp_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    // input stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // doc_word[63:0], query_plane_0..3 [127:64..319:256], valid_bytes[323:320], zero pad
    input  logic [bpdp_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    input  logic                             s_axis_tlast,
    // result stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // dot_product[31:0]
    output logic [bpdp_pkg::M_TDATA_W-1:0]   m_axis_tdata
);
    import bpdp_pkg::*;

    logic                r_two_bit;
    logic                r_s1_valid;
    logic [DOC_W-1:0]    r_s1_word;
    t_plane_words        r_s1_planes;
    logic [NBYTES_W-1:0] r_s1_nbytes;
    logic                r_s1_last;
    logic                r_s2_valid;
    logic                r_s2_last;
    logic [SUM_W-1:0]    r_s2_sum;
    t_sum_beat           s2_beat;
    logic [SUM_W-1:0]    s1_sum;
    logic                s2_take;
    logic                s2_load;
    logic                s1_load;
    logic                cfg_write;

    // configuration; the single register answers at every byte offset of its word
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign prdata    = {{(APB_DATA_W-1){1'b0}}, r_two_bit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_two_bit <= 1'b0;
        end else if (cfg_write && ((paddr >> 2) == APB_ADDR_W'(REG_TWO_BIT_CODES))) begin
            r_two_bit <= pwdata[0];
        end
    end

    // stage enables ripple back from the accumulator
    assign s2_load       = !r_s2_valid || s2_take;
    assign s1_load       = !r_s1_valid || s2_load;
    assign s_axis_tready = s1_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (s1_load) begin
                r_s1_valid <= s_axis_tvalid;
            end
            if (s2_load) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load && s_axis_tvalid) begin
            r_s1_word   <= s_axis_tdata[DOC_W-1:0];
            for (int p = 0; p < PLANE_INPUTS; p++) begin
                r_s1_planes[p] <= s_axis_tdata[DOC_W*(p+1) +: DOC_W];
            end
            r_s1_nbytes <= s_axis_tdata[DOC_W*(PLANE_INPUTS+1) +: NBYTES_W];
            r_s1_last   <= s_axis_tlast;
        end
        if (s2_load && r_s1_valid) begin
            r_s2_last <= r_s1_last;
            r_s2_sum  <= s1_sum;
        end
    end

    assign s2_beat = {r_s2_valid, r_s2_last, r_s2_sum};

    bpdp_popcount u_popcount (
        .i_doc_word    (r_s1_word),
        .i_planes      (r_s1_planes),
        .i_valid_bytes (r_s1_nbytes),
        .i_two_bit     (r_two_bit),
        .o_sum         (s1_sum)
    );

    bpdp_accum u_accum (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_beat     (s2_beat),
        .o_take     (s2_take),
        .i_m_tready (m_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .o_m_tdata  (m_axis_tdata)
    );

endmodule

@@ rtl/bpdp_checker.sv @@
// port-level checks for the bit-plane dot product block, bound to the top level
`include "bitplane_popcount_dot_product_macros.svh"

module bpdp_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             psel,
    input logic                             penable,
    input logic                             pwrite,
    input logic [bpdp_pkg::APB_ADDR_W-1:0]  paddr,
    input logic [bpdp_pkg::APB_DATA_W-1:0]  pwdata,
    input logic [bpdp_pkg::APB_DATA_W-1:0]  prdata,
    input logic                             pready,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [bpdp_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    input logic                             s_axis_tlast,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [bpdp_pkg::M_TDATA_W-1:0]   m_axis_tdata
);
    import bpdp_pkg::*;

    // a pending result holds until taken
    `BPDP_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // nothing is offered straight after reset
    `BPDP_ASSERT_NOW(a_reset_empty, !$past(i_rst_n), !m_axis_tvalid)

    // with the result register empty the pipeline cannot be backed up
    `BPDP_ASSERT_NOW(a_ready_when_empty, !m_axis_tvalid, s_axis_tready)

    // a mode write reads back on the next cycle
    `BPDP_ASSERT_NEXT(a_cfg_readback, psel && penable && pwrite && pready, prdata[0] == $past(pwdata[0]) && prdata[APB_DATA_W-1:1] == '0)

endmodule

bind bitplane_popcount_dot_product bpdp_checker u_bpdp_checker (.*);

@@ tb/sv/tb_bitplane_popcount_dot_product.sv @@
// self-checking testbench for the bit-plane popcount dot product block
module tb_bitplane_popcount_dot_product;
    timeunit 1ns;
    timeprecision 1ps;

    import bpdp_pkg::*;

    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 212;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int STALL_LIMIT     = 3000;
    localparam int SETTLE_CYCLES   = 8;

    localparam logic [APB_ADDR_W-1:0] ADDR_TWO_BIT_CODES = APB_ADDR_W'(4 * REG_TWO_BIT_CODES);

    // running totals per document vector, predicted from the accepted beats
    class dot_product_scoreboard;
        bit          two_bit_mode;
        logic [31:0] running_total = '0;
        logic [31:0] pending_totals[$];
        int          errors;

        function logic [31:0] weighted_popcount(logic [63:0] doc, t_plane_words planes,
                                                logic [3:0] nbytes);
            logic [63:0] word, lo, hi;
            logic [31:0] sum;
            int          n;
            n    = (nbytes > 4'd8) ? 8 : int'(nbytes);
            word = doc;
            if (n < 8)
                word = doc & ((64'd1 << (n * 8)) - 64'd1);
            if (two_bit_mode) begin
                lo = word & EVEN_BITS;
                hi = (word >> 1) & EVEN_BITS;
            end else begin
                lo = word;
                hi = '0;
            end
            sum = '0;
            for (int p = 0; p < PLANES_USED; p++)
                sum += (32'($countones(lo & planes[p])) +
                        32'(2 * $countones(hi & planes[p]))) << p;
            return sum;
        endfunction

        function void note_beat(logic [63:0] doc, t_plane_words planes, logic [3:0] nbytes,
                                logic last);
            running_total += weighted_popcount(doc, planes, nbytes);
            if (last) begin
                pending_totals.push_back(running_total);
                running_total = '0;
            end
        endfunction

        function void check_result(logic [31:0] actual);
            logic [31:0] expected_total;
            if (pending_totals.size() == 0) begin
                $display("%t unexpected dot_product beat: expected none got %h", $time, actual);
                errors++;
            end else begin
                expected_total = pending_totals.pop_front();
                if (actual !== expected_total) begin
                    $display("%t dot_product mismatch: expected %h got %h",
                             $time, expected_total, actual);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [APB_ADDR_W-1:0] paddr         = '0;
    logic [APB_DATA_W-1:0] pwdata        = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // doc_word, query_plane_0..3, valid_bytes, zero pad
    logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                  s_axis_tlast  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // dot_product
    logic [M_TDATA_W-1:0]  m_axis_tdata;

    dot_product_scoreboard totals;
    bit sender_idles     = 1'b1;
    bit receiver_idles   = 1'b1;
    bit hold_off_request = 1'b0;

    bitplane_popcount_dot_product dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #6 i_clk = ~i_clk;

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [63:0] rand_word();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '1;
        if (r < 14)
            return '0;
        if (r < 20)
            return 64'd1 << $urandom_range(0, 63);
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [3:0] rand_nbytes();
        if ($urandom_range(0, 99) < 70)
            return 4'd8;
        return 4'($urandom_range(0, 15));
    endfunction

    task automatic send_beat(logic [63:0] doc, t_plane_words planes, logic [3:0] nbytes,
                             logic last);
        int gap;
        gap = sender_idles ? pick_gap() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, nbytes, planes, doc};
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        totals.note_beat(doc, planes, nbytes, last);
    endtask

    // wait for every outstanding total, then let the pipeline drain
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (totals.pending_totals.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_code_mode(bit mode);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_TWO_BIT_CODES;
        pwdata  <= APB_DATA_W'(mode);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        totals.two_bit_mode = mode;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        // read back
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== APB_DATA_W'(mode)) begin
            $display("%t two_bit_codes read mismatch: expected %h got %h",
                     $time, APB_DATA_W'(mode), prdata);
            totals.errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // result side ready pattern, including one long hold-off
    initial begin : result_ready
        int gap;
        int burst;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end else if (!receiver_idles) begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end else begin
                gap = pick_gap();
                if (gap > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                burst = $urandom_range(1, 6);
                m_axis_tready <= 1'b1;
                repeat (burst) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            totals.check_result(m_axis_tdata);
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
                quiet = 0;
            else
                quiet++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        t_plane_words all_ones;
        t_plane_words pl;
        int           sent;
        int           len;
        totals = new();
        all_ones = {PLANE_INPUTS{64'hFFFF_FFFF_FFFF_FFFF}};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // one-bit codes: extremes, byte count edges, planes one by one
        write_code_mode(1'b0);
        send_beat('0, '0, 4'd8, 1'b1);
        send_beat('1, all_ones, 4'd8, 1'b1);
        send_beat('1, all_ones, 4'd0, 1'b1);
        send_beat('1, all_ones, 4'd9, 1'b1);
        send_beat('1, all_ones, 4'd15, 1'b1);
        for (int nb = 1; nb <= 7; nb++)
            send_beat('1, all_ones, 4'(nb), nb == 7);
        for (int p = 0; p < PLANE_INPUTS; p++) begin
            pl    = '0;
            pl[p] = '1;
            send_beat('1, pl, 4'd8, p == PLANE_INPUTS - 1);
        end
        settle();

        // two-bit codes: low bits only, high bits only, both, partial words
        write_code_mode(1'b1);
        send_beat('1, all_ones, 4'd8, 1'b1);
        send_beat(64'hAAAA_AAAA_AAAA_AAAA, all_ones, 4'd8, 1'b1);
        send_beat(64'h5555_5555_5555_5555, all_ones, 4'd8, 1'b1);
        send_beat('1, all_ones, 4'd3, 1'b0);
        send_beat('1, all_ones, 4'd12, 1'b1);
        settle();

        for (int phase = 0; phase < PHASES; phase++) begin
            sender_idles   = (phase != 2) && (phase != 5);
            receiver_idles = (phase != 2) && (phase != 6);
            write_code_mode(1'(phase % 2));
            // short vectors so the block fills up behind the stalled result side
            if (phase == 4)
                hold_off_request = 1'b1;
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                if (phase == 4)
                    len = $urandom_range(1, 2);
                else if ($urandom_range(0, 99) < 85)
                    len = $urandom_range(1, 6);
                else
                    len = $urandom_range(7, 40);
                for (int k = 0; k < len; k++) begin
                    for (int p = 0; p < PLANE_INPUTS; p++)
                        pl[p] = rand_word();
                    send_beat(rand_word(), pl, rand_nbytes(), k == len - 1);
                end
                sent += len;
            end
            settle();
        end

        if (totals.errors == 0 && totals.pending_totals.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/bpdp_pkg.sv
rtl/bpdp_popcount.sv
rtl/bpdp_accum.sv
rtl/bitplane_popcount_dot_product.sv
rtl/bpdp_checker.sv
tb/sv/tb_bitplane_popcount_dot_product.sv
